@@ rtl/coapmp_pkg.sv @@
// Shared types and constants of the CoAP message parser.
`timescale 1ns / 1ps

package coapmp_pkg;

    // Parse phase of the current datagram
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TOKEN   = 3'd1,
        PH_DEXT    = 3'd2,
        PH_LEXT    = 3'd3,
        PH_OPTHDR  = 3'd4,
        PH_VALUE   = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    // Byte classes reported per item
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_TOKEN   = 3'd1;
    localparam logic [2:0] KIND_OPTHDR  = 3'd2;
    localparam logic [2:0] KIND_VALUE   = 3'd3;
    localparam logic [2:0] KIND_MARKER  = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_SKIPPED = 3'd6;
    localparam logic [2:0] KIND_ERROR   = 3'd7;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
    localparam logic [2:0] ST_SHORT_TOK  = 3'd2;
    localparam logic [2:0] ST_SHORT_OPT  = 3'd3;
    localparam logic [2:0] ST_RESERVED   = 3'd4;
    localparam logic [2:0] ST_NUM_OVFL   = 3'd5;

    // Option field encoding
    localparam logic [7:0]  PAYLOAD_MARKER  = 8'hFF;
    localparam logic [3:0]  NIB_EXT8        = 4'd13;
    localparam logic [3:0]  NIB_RESERVED    = 4'd15;
    localparam logic [16:0] EXT8_OFFSET     = 17'd13;
    localparam logic [16:0] EXT16_OFFSET    = 17'd269;
    localparam logic [1:0]  LAST_HDR_BYTE   = 2'd3;

    // Option count limit
    localparam int unsigned LIMIT_W          = 6;
    localparam logic [LIMIT_W-1:0] MAX_OPTIONS   = 6'd32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 6'd32;

    // Register map (word index taken from paddr[2])
    localparam logic REG_OPTION_LIMIT = 1'b0;

endpackage

@@ rtl/coap_message_parser_core.sv @@
// Byte-serial CoAP (RFC 7252) message parser with one registered result per byte.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  input   | in        | i_valid / o_stall      | i_data_byte, i_end_of_datagram
//  result  | out       | o_valid / i_stall      | o_byte_kind .. o_status
//  config  | in        | psel/penable/pready    | paddr, pwdata, prdata (option_limit)
//
//  One byte is taken per cycle while o_stall is low; its result appears in the output register on the next cycle.
//  The parse state and the result register update at the same edge.
//  While a result waits under i_stall, o_stall holds the input; a drained result frees it.
//  Synchronous active-low reset clears the parse state, the result valid and sets limit to 32.
//  The parse state returns to its reset value after each byte flagged end of datagram.
`timescale 1ns / 1ps

module coap_message_parser_core
    import coapmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_datagram,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_byte_kind,
    output logic [7:0]  o_byte_echo,
    output logic [15:0] o_option_number,
    output logic [16:0] o_option_length,
    output logic        o_option_ready,
    output logic [1:0]  o_version,
    output logic [1:0]  o_msg_type,
    output logic [3:0]  o_token_length,
    output logic [7:0]  o_msg_code,
    output logic [15:0] o_msg_ident,
    output logic        o_last,
    output logic [2:0]  o_status,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Parse state
    t_phase              r_phase,          n_phase;
    logic [1:0]          r_header_count,   n_header_count;
    logic [3:0]          r_token_left,     n_token_left;
    logic [1:0]          r_ext_left,       n_ext_left;
    logic [16:0]         r_delta_accum,    n_delta_accum;
    logic [16:0]         r_length_accum,   n_length_accum;
    logic [7:0]          r_pending,        n_pending;
    logic [15:0]         r_prev_option,    n_prev_option;
    logic [16:0]         r_value_left,     n_value_left;
    logic [LIMIT_W-1:0]  r_options_seen,   n_options_seen;
    logic [31:0]         r_header_fields,  n_header_fields;
    logic [2:0]          r_error_code,     n_error_code;
    logic                r_value_reported, n_value_reported;

    logic [LIMIT_W-1:0]  r_option_limit;

    // Result register
    logic                r_out_valid;
    logic [2:0]          r_kind;
    logic [7:0]          r_echo;
    logic [15:0]         r_opt_num;
    logic [16:0]         r_opt_len;
    logic                r_opt_ready;
    logic [31:0]         r_hdr;
    logic                r_last;
    logic [2:0]          r_status;

    logic                in_accept;
    logic                cfg_write;
    logic                finish_ok;
    logic [2:0]          kind;
    logic [LIMIT_W-1:0]  eff_limit;

    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;
    assign cfg_write = psel & penable & pwrite & pready;
    assign eff_limit = (r_option_limit < MAX_OPTIONS) ? r_option_limit : MAX_OPTIONS;

    // Next parse state for the incoming byte
    always_comb begin
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic        do_finish;
        logic [16:0] fin_delta;
        logic [16:0] fin_len;
        logic [17:0] fin_num;

        n_phase          = r_phase;
        n_header_count   = r_header_count;
        n_token_left     = r_token_left;
        n_ext_left       = r_ext_left;
        n_delta_accum    = r_delta_accum;
        n_length_accum   = r_length_accum;
        n_pending        = r_pending;
        n_prev_option    = r_prev_option;
        n_value_left     = r_value_left;
        n_options_seen   = r_options_seen;
        n_header_fields  = r_header_fields;
        n_error_code     = r_error_code;
        n_value_reported = r_value_reported;
        do_finish        = 1'b0;
        finish_ok        = 1'b0;
        hi               = i_data_byte[7:4];
        lo               = i_data_byte[3:0];

        case (r_phase)
            PH_HEADER: begin
                case (r_header_count)
                    2'd0:    n_header_fields[31:24] = i_data_byte;
                    2'd1:    n_header_fields[23:16] = i_data_byte;
                    2'd2:    n_header_fields[15:8]  = i_data_byte;
                    default: n_header_fields[7:0]   = i_data_byte;
                endcase
                if (r_header_count == LAST_HDR_BYTE) begin
                    n_header_count = 2'd0;
                    n_token_left   = n_header_fields[27:24];
                    n_phase        = (n_header_fields[27:24] != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                end else begin
                    n_header_count = r_header_count + 2'd1;
                end
            end
            PH_TOKEN: begin
                n_token_left = r_token_left - 4'd1;
                if (n_token_left == 4'd0) begin
                    n_phase = PH_OPTHDR;
                end
            end
            PH_OPTHDR: begin
                if (i_data_byte == PAYLOAD_MARKER) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_pending      = i_data_byte;
                    n_delta_accum  = 17'd0;
                    n_length_accum = 17'd0;
                    if (hi == NIB_RESERVED || lo == NIB_RESERVED) begin
                        if (r_error_code == ST_OK) begin
                            n_error_code = ST_RESERVED;
                        end
                        n_phase = PH_ERROR;
                    end else if (hi >= NIB_EXT8) begin
                        n_ext_left = (hi == NIB_EXT8) ? 2'd1 : 2'd2;
                        n_phase    = PH_DEXT;
                    end else if (lo >= NIB_EXT8) begin
                        n_ext_left = (lo == NIB_EXT8) ? 2'd1 : 2'd2;
                        n_phase    = PH_LEXT;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_DEXT: begin
                n_delta_accum = {1'b0, r_delta_accum[7:0], i_data_byte};
                n_ext_left    = r_ext_left - 2'd1;
                if (n_ext_left == 2'd0) begin
                    n_delta_accum = n_delta_accum +
                        ((r_pending[7:4] == NIB_EXT8) ? EXT8_OFFSET : EXT16_OFFSET);
                    if (r_pending[3:0] >= NIB_EXT8) begin
                        n_ext_left = (r_pending[3:0] == NIB_EXT8) ? 2'd1 : 2'd2;
                        n_phase    = PH_LEXT;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_LEXT: begin
                n_length_accum = {1'b0, r_length_accum[7:0], i_data_byte};
                n_ext_left     = r_ext_left - 2'd1;
                if (n_ext_left == 2'd0) begin
                    n_length_accum = n_length_accum +
                        ((r_pending[3:0] == NIB_EXT8) ? EXT8_OFFSET : EXT16_OFFSET);
                    do_finish = 1'b1;
                end
            end
            PH_VALUE: begin
                n_value_left = r_value_left - 17'd1;
                if (n_value_left == 17'd0) begin
                    n_phase = PH_OPTHDR;
                end
            end
            default: begin
            end
        endcase

        // Close the option header: resolve delta and length, advance the number
        fin_delta = (n_pending[7:4] < NIB_EXT8) ? {13'd0, n_pending[7:4]} : n_delta_accum;
        fin_len   = (n_pending[3:0] < NIB_EXT8) ? {13'd0, n_pending[3:0]} : n_length_accum;
        fin_num   = {2'b00, r_prev_option} + {1'b0, fin_delta};
        if (do_finish) begin
            n_delta_accum  = fin_delta;
            n_length_accum = fin_len;
            if (fin_num[17:16] != 2'b00) begin
                if (r_error_code == ST_OK) begin
                    n_error_code = ST_NUM_OVFL;
                end
                n_phase = PH_ERROR;
            end else begin
                finish_ok     = 1'b1;
                n_prev_option = fin_num[15:0];
                n_value_left  = fin_len;
                if (r_options_seen < eff_limit) begin
                    n_options_seen   = r_options_seen + 1'b1;
                    n_value_reported = 1'b1;
                end else begin
                    n_value_reported = 1'b0;
                end
                n_phase = (fin_len != 17'd0) ? PH_VALUE : PH_OPTHDR;
            end
        end

        // Flag truncation on the final byte
        if (i_end_of_datagram && n_error_code == ST_OK) begin
            if (n_phase == PH_HEADER) begin
                n_error_code = ST_SHORT_HDR;
            end else if (n_phase == PH_TOKEN) begin
                n_error_code = ST_SHORT_TOK;
            end else if (n_phase == PH_DEXT || n_phase == PH_LEXT || n_phase == PH_VALUE) begin
                n_error_code = ST_SHORT_OPT;
            end
        end
    end

    // Byte class for the incoming byte
    always_comb begin
        case (r_phase)
            PH_HEADER:  kind = KIND_HEADER;
            PH_TOKEN:   kind = KIND_TOKEN;
            PH_OPTHDR:  kind = (i_data_byte == PAYLOAD_MARKER) ? KIND_MARKER : KIND_OPTHDR;
            PH_DEXT:    kind = KIND_OPTHDR;
            PH_LEXT:    kind = KIND_OPTHDR;
            PH_VALUE:   kind = r_value_reported ? KIND_VALUE : KIND_SKIPPED;
            PH_PAYLOAD: kind = KIND_PAYLOAD;
            default:    kind = KIND_ERROR;
        endcase
    end

    // Advance parse state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_accept && i_end_of_datagram)) begin
            r_phase          <= PH_HEADER;
            r_header_count   <= 2'd0;
            r_token_left     <= 4'd0;
            r_ext_left       <= 2'd0;
            r_delta_accum    <= 17'd0;
            r_length_accum   <= 17'd0;
            r_pending        <= 8'd0;
            r_prev_option    <= 16'd0;
            r_value_left     <= 17'd0;
            r_options_seen   <= '0;
            r_header_fields  <= 32'd0;
            r_error_code     <= ST_OK;
            r_value_reported <= 1'b0;
        end else if (in_accept) begin
            r_phase          <= n_phase;
            r_header_count   <= n_header_count;
            r_token_left     <= n_token_left;
            r_ext_left       <= n_ext_left;
            r_delta_accum    <= n_delta_accum;
            r_length_accum   <= n_length_accum;
            r_pending        <= n_pending;
            r_prev_option    <= n_prev_option;
            r_value_left     <= n_value_left;
            r_options_seen   <= n_options_seen;
            r_header_fields  <= n_header_fields;
            r_error_code     <= n_error_code;
            r_value_reported <= n_value_reported;
        end
    end

    // Result valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind      <= kind;
            r_echo      <= i_data_byte;
            r_opt_num   <= n_prev_option;
            r_opt_len   <= n_length_accum;
            r_opt_ready <= finish_ok;
            r_hdr       <= n_header_fields;
            r_last      <= i_end_of_datagram;
            r_status    <= n_error_code;
        end
    end

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_option_limit <= LIMIT_RESET;
        end else if (cfg_write && paddr[2] == REG_OPTION_LIMIT) begin
            r_option_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OPTION_LIMIT) ?
                    {{(32-LIMIT_W){1'b0}}, r_option_limit} : 32'd0;

    assign o_valid         = r_out_valid;
    assign o_byte_kind     = r_kind;
    assign o_byte_echo     = r_echo;
    assign o_option_number = r_opt_num;
    assign o_option_length = r_opt_len;
    assign o_option_ready  = r_opt_ready;
    assign o_version       = r_hdr[31:30];
    assign o_msg_type      = r_hdr[29:28];
    assign o_token_length  = r_hdr[27:24];
    assign o_msg_code      = r_hdr[23:16];
    assign o_msg_ident     = r_hdr[15:0];
    assign o_last          = r_last;
    assign o_status        = r_status;

endmodule

@@ rtl/coapmp_checker.sv @@
// Port-level checks of the CoAP message parser and their bind.
`timescale 1ns / 1ps

module coapmp_checker
    import coapmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_datagram,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [2:0]  o_byte_kind,
    input  logic [7:0]  o_byte_echo,
    input  logic        o_option_ready,
    input  logic        o_last,
    input  logic        pready
);

    // Hold the input side only while a result waits
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // Every accepted item yields a result on the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted item produced no result");

    // Result echoes the accepted byte and its end flag
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_byte_echo == $past(i_data_byte) &&
                                   o_last == $past(i_end_of_datagram)))
        else $error("result does not match accepted byte");

    // A completed option header is always an option header byte
    a_ready_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_option_ready) |-> (o_byte_kind == KIND_OPTHDR))
        else $error("option_ready on a non-header byte");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind coap_message_parser_core coapmp_checker u_coapmp_checker (.*);

@@ tb/coap_message_parser_core_tb.sv @@
// Testbench for the CoAP parser core: directed and random datagrams checked byte by byte.
`timescale 1ns / 1ps

module coap_message_parser_core_tb;
    import coapmp_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_BYTES = 140;
    localparam logic [2:0] LIMIT_ADDR = {REG_OPTION_LIMIT, 2'b00};

    // One parse result, as the block reports it per byte
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  echo;
        logic [15:0] opt_number;
        logic [16:0] opt_length;
        logic        opt_ready;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  tkl;
        logic [7:0]  code;
        logic [15:0] msg_id;
        logic        last;
        logic [2:0]  status;
    } t_coap_result;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte       = 8'h00;
    logic        i_end_of_datagram = 1'b0;
    logic        o_valid;
    logic        i_stall           = 1'b0;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_byte_echo;
    logic [15:0] o_option_number;
    logic [16:0] o_option_length;
    logic        o_option_ready;
    logic [1:0]  o_version;
    logic [1:0]  o_msg_type;
    logic [3:0]  o_token_length;
    logic [7:0]  o_msg_code;
    logic [15:0] o_msg_ident;
    logic        o_last;
    logic [2:0]  o_status;
    logic        psel              = 1'b0;
    logic        penable           = 1'b0;
    logic        pwrite            = 1'b0;
    logic [2:0]  paddr             = 3'd0;
    logic [31:0] pwdata            = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    coap_message_parser_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_byte_kind       (o_byte_kind),
        .o_byte_echo       (o_byte_echo),
        .o_option_number   (o_option_number),
        .o_option_length   (o_option_length),
        .o_option_ready    (o_option_ready),
        .o_version         (o_version),
        .o_msg_type        (o_msg_type),
        .o_token_length    (o_token_length),
        .o_msg_code        (o_msg_code),
        .o_msg_ident       (o_msg_ident),
        .o_last            (o_last),
        .o_status          (o_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Parser mirror: state of the datagram being walked
    t_phase      parse_phase;
    logic [1:0]  hdr_count;
    logic [3:0]  token_due;
    logic [1:0]  ext_due;
    logic [16:0] delta_sum;
    logic [16:0] length_sum;
    logic [7:0]  option_hdr;
    logic [15:0] last_option;
    logic [16:0] value_due;
    logic [5:0]  options_counted;
    logic [31:0] header_word;
    logic [2:0]  latched_status;
    logic        value_visible;
    logic [5:0]  option_limit_reg;

    t_coap_result pending_results[$];
    logic [7:0]   dgram[$];
    t_coap_result want;
    int mismatches      = 0;
    int results_checked = 0;
    int bytes_sent      = 0;
    int burst_left      = 0;
    int cycles          = 0;
    int stall_mode      = 0;
    int stall_run       = 0;

    // Clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stall pattern: switch between free, light, half and heavy stretches
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 200);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic compare_value(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s mismatch, expected 0x%0h, got 0x%0h",
                         results_checked, what, want_v, got_v);
        end
    endtask

    // Check each drained result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d byte 0x%0h", o_byte_kind, o_byte_echo);
            end else begin
                want = pending_results.pop_front();
                compare_value("byte_kind", want.kind, o_byte_kind);
                compare_value("byte_echo", want.echo, o_byte_echo);
                compare_value("option_number", want.opt_number, o_option_number);
                compare_value("option_length", want.opt_length, o_option_length);
                compare_value("option_ready", want.opt_ready, o_option_ready);
                compare_value("version", want.version, o_version);
                compare_value("msg_type", want.msg_type, o_msg_type);
                compare_value("token_length", want.tkl, o_token_length);
                compare_value("msg_code", want.code, o_msg_code);
                compare_value("msg_ident", want.msg_id, o_msg_ident);
                compare_value("last", want.last, o_last);
                compare_value("status", want.status, o_status);
            end
            results_checked++;
        end
    end

    function automatic void clear_parse_state();
        parse_phase     = PH_HEADER;
        hdr_count       = '0;
        token_due       = '0;
        ext_due         = '0;
        delta_sum       = '0;
        length_sum      = '0;
        option_hdr      = '0;
        last_option     = '0;
        value_due       = '0;
        options_counted = '0;
        header_word     = '0;
        latched_status  = ST_OK;
        value_visible   = 1'b0;
    endfunction

    function automatic void latch_error(input logic [2:0] code);
        if (latched_status == ST_OK)
            latched_status = code;
        parse_phase = PH_ERROR;
    endfunction

    // All nibbles and extension bytes are in: resolve the option, return its ready flag
    function automatic logic close_option();
        int unsigned num;
        int unsigned lim;
        if (option_hdr[7:4] < NIB_EXT8)
            delta_sum = 17'(option_hdr[7:4]);
        if (option_hdr[3:0] < NIB_EXT8)
            length_sum = 17'(option_hdr[3:0]);
        lim = (option_limit_reg < MAX_OPTIONS) ? option_limit_reg : MAX_OPTIONS;
        num = last_option + delta_sum;
        if (num > 32'd65535) begin
            latch_error(ST_NUM_OVFL);
            return 1'b0;
        end
        last_option = 16'(num);
        value_due   = length_sum;
        if (options_counted < lim) begin
            options_counted++;
            value_visible = 1'b1;
        end else begin
            value_visible = 1'b0;
        end
        parse_phase = (value_due != 0) ? PH_VALUE : PH_OPTHDR;
        return 1'b1;
    endfunction

    // Expected result of one accepted byte; advances the mirror state
    function automatic t_coap_result next_parse_result(input logic [7:0] b, input logic eod);
        t_coap_result r;
        logic [2:0]   kind;
        logic         rdy;
        kind = KIND_ERROR;
        rdy  = 1'b0;
        case (parse_phase)
            PH_HEADER: begin
                kind = KIND_HEADER;
                header_word |= 32'(b) << (8 * (LAST_HDR_BYTE - hdr_count));
                if (hdr_count == LAST_HDR_BYTE) begin
                    hdr_count   = '0;
                    token_due   = header_word[27:24];
                    parse_phase = (token_due != 0) ? PH_TOKEN : PH_OPTHDR;
                end else begin
                    hdr_count++;
                end
            end
            PH_TOKEN: begin
                kind = KIND_TOKEN;
                token_due--;
                if (token_due == 0)
                    parse_phase = PH_OPTHDR;
            end
            PH_OPTHDR: begin
                if (b == PAYLOAD_MARKER) begin
                    kind        = KIND_MARKER;
                    parse_phase = PH_PAYLOAD;
                end else begin
                    kind       = KIND_OPTHDR;
                    option_hdr = b;
                    delta_sum  = '0;
                    length_sum = '0;
                    if (b[7:4] == NIB_RESERVED || b[3:0] == NIB_RESERVED) begin
                        latch_error(ST_RESERVED);
                    end else if (b[7:4] >= NIB_EXT8) begin
                        ext_due     = 2'(b[7:4] - NIB_EXT8 + 4'd1);
                        parse_phase = PH_DEXT;
                    end else if (b[3:0] >= NIB_EXT8) begin
                        ext_due     = 2'(b[3:0] - NIB_EXT8 + 4'd1);
                        parse_phase = PH_LEXT;
                    end else begin
                        rdy = close_option();
                    end
                end
            end
            PH_DEXT: begin
                kind      = KIND_OPTHDR;
                delta_sum = {1'b0, delta_sum[7:0], b};
                ext_due--;
                if (ext_due == 0) begin
                    delta_sum += (option_hdr[7:4] == NIB_EXT8) ? EXT8_OFFSET : EXT16_OFFSET;
                    if (option_hdr[3:0] >= NIB_EXT8) begin
                        ext_due     = 2'(option_hdr[3:0] - NIB_EXT8 + 4'd1);
                        parse_phase = PH_LEXT;
                    end else begin
                        rdy = close_option();
                    end
                end
            end
            PH_LEXT: begin
                kind       = KIND_OPTHDR;
                length_sum = {1'b0, length_sum[7:0], b};
                ext_due--;
                if (ext_due == 0) begin
                    length_sum += (option_hdr[3:0] == NIB_EXT8) ? EXT8_OFFSET : EXT16_OFFSET;
                    rdy = close_option();
                end
            end
            PH_VALUE: begin
                kind = value_visible ? KIND_VALUE : KIND_SKIPPED;
                value_due--;
                if (value_due == 0)
                    parse_phase = PH_OPTHDR;
            end
            PH_PAYLOAD: kind = KIND_PAYLOAD;
            default:    kind = KIND_ERROR;
        endcase

        // Flag a datagram that ends mid-structure
        if (eod && latched_status == ST_OK) begin
            case (parse_phase)
                PH_HEADER: latched_status = ST_SHORT_HDR;
                PH_TOKEN:  latched_status = ST_SHORT_TOK;
                PH_DEXT, PH_LEXT, PH_VALUE: latched_status = ST_SHORT_OPT;
                default: ;
            endcase
        end

        r.kind       = kind;
        r.echo       = b;
        r.opt_number = last_option;
        r.opt_length = length_sum;
        r.opt_ready  = rdy;
        r.version    = header_word[31:30];
        r.msg_type   = header_word[29:28];
        r.tkl        = header_word[27:24];
        r.code       = header_word[23:16];
        r.msg_id     = header_word[15:0];
        r.last       = eod;
        r.status     = latched_status;
        if (eod)
            clear_parse_state();
        return r;
    endfunction

    // Send one item; the sender runs in bursts with random gaps between them
    task automatic send_item(input logic [7:0] data, input logic eod);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid           <= 1'b1;
        i_data_byte       <= data;
        i_end_of_datagram <= eod;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        pending_results.push_back(next_parse_result(data, eod));
        bytes_sent++;
    endtask

    // Hold the input until every expected result has drained
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One register transfer: setup phase, access phase, then back to idle
    task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_option_limit(input logic [5:0] value);
        logic [31:0] rdata;
        apb_transfer(1'b1, {26'd0, value}, rdata);
        option_limit_reg = value;
        apb_transfer(1'b0, 32'd0, rdata);
        compare_value("option_limit readback", {26'd0, option_limit_reg}, rdata);
    endtask

    // Send the first count bytes of the datagram, optionally draining before one of them
    task automatic send_datagram(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                wait_for_results();
            send_item(dgram[i], i == count - 1);
        end
    endtask

    function automatic logic [3:0] nibble_code(input int v);
        if (v < EXT8_OFFSET)
            return 4'(v);
        return (v < EXT16_OFFSET) ? NIB_EXT8 : NIB_EXT8 + 4'd1;
    endfunction

    function automatic void push_extension(input int v);
        if (v >= EXT16_OFFSET) begin
            dgram.push_back(8'((v - EXT16_OFFSET) >> 8));
            dgram.push_back(8'(v - EXT16_OFFSET));
        end else if (v >= EXT8_OFFSET) begin
            dgram.push_back(8'(v - EXT8_OFFSET));
        end
    endfunction

    function automatic void append_option(input int delta, input int len);
        dgram.push_back({nibble_code(delta), nibble_code(len)});
        push_extension(delta);
        push_extension(len);
        repeat (len) dgram.push_back(8'($urandom));
    endfunction

    // Build a well-formed message with random content; optionally end it in a number overflow
    task automatic build_message(input bit overflow);
        int tkl, n_opts, cur, d, len, r;
        dgram.delete();
        tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        dgram.push_back({($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd1,
                         2'($urandom), 4'(tkl)});
        repeat (3) dgram.push_back(8'($urandom));
        repeat (tkl) dgram.push_back(8'($urandom));
        n_opts = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 5);
        cur = 0;
        repeat (n_opts) begin
            r = $urandom_range(0, 19);
            if (r < 12)
                d = $urandom_range(0, 12);
            else if (r < 18)
                d = $urandom_range(13, 268);
            else if (r < 19)
                d = $urandom_range(269, 1500);
            else
                d = $urandom_range(269, 65535);
            if (d > 65535 - cur)
                d = 0;
            cur += d;
            r = $urandom_range(0, 99);
            if (n_opts >= 30)
                len = $urandom_range(0, 1);
            else if (r < 70)
                len = $urandom_range(0, 4);
            else if (r < 88)
                len = $urandom_range(5, 12);
            else if (r < 99)
                len = $urandom_range(13, 20);
            else
                len = $urandom_range(269, 272);
            append_option(d, len);
        end
        if (overflow) begin
            append_option($urandom_range(33000, 65804), 0);
            append_option($urandom_range(33000, 65804), 0);
        end
        if ($urandom_range(0, 2) != 0) begin
            dgram.push_back(PAYLOAD_MARKER);
            repeat ($urandom_range(0, 10)) dgram.push_back(8'($urandom));
        end
    endtask

    // Break a message: cut it short, corrupt a byte, plant a reserved nibble, or replace it
    task automatic damage_message(output int keep);
        int pos;
        keep = dgram.size();
        case ($urandom_range(0, 3))
            0: keep = $urandom_range(1, dgram.size());
            1: begin
                pos = $urandom_range(0, dgram.size() - 1);
                dgram[pos] = 8'($urandom);
            end
            2: begin
                pos = $urandom_range(4, dgram.size());
                if ($urandom_range(0, 1) == 0)
                    dgram.insert(pos, {NIB_RESERVED, 4'($urandom)});
                else
                    dgram.insert(pos, {4'($urandom), NIB_RESERVED});
                keep = dgram.size();
            end
            default: begin
                dgram.delete();
                repeat ($urandom_range(1, 16)) dgram.push_back(8'($urandom));
                keep = dgram.size();
            end
        endcase
    endtask

    // Mostly well-formed datagrams, some broken, a few paused at a random byte until drained
    task automatic run_traffic(input int budget);
        int start, keep, pause_at;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            build_message($urandom_range(0, 19) == 0);
            keep = dgram.size();
            if ($urandom_range(0, 5) == 0)
                damage_message(keep);
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, keep - 1) : -1;
            send_datagram(keep, pause_at);
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] rdata;
        apb_transfer(1'b0, 32'd0, rdata);
        compare_value("option_limit after reset", {26'd0, LIMIT_RESET}, rdata);
    endtask

    task automatic test_directed_cases();
        // header cut short
        dgram = '{8'h40, 8'h01};
        send_datagram(dgram.size(), -1);
        // all-ones header, token length 15, token cut short
        dgram = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_datagram(dgram.size(), -1);
        // marker with empty payload
        dgram = '{8'h50, 8'h45, 8'h00, 8'h00, PAYLOAD_MARKER};
        send_datagram(dgram.size(), -1);
        // reserved delta nibble, then bytes after the error
        dgram = '{8'h60, 8'h02, 8'h12, 8'h34, 8'hF1, 8'h33};
        send_datagram(dgram.size(), -1);
        // option number 65535, then one more pushes it past the top
        dgram = '{8'h40, 8'h01, 8'hAB, 8'hCD, 8'hE0, 8'hFE, 8'hF2, 8'h10, 8'h22};
        send_datagram(dgram.size(), -1);
        // largest option length, value cut short
        dgram = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h0E, 8'hFF, 8'hFF, 8'h01, 8'h02};
        send_datagram(dgram.size(), -1);
        // one-byte extended delta and length, value cut short
        dgram = '{8'h70, 8'hFF, 8'h00, 8'h01, 8'hDD, 8'h00, 8'h00, 8'hAA};
        send_datagram(dgram.size(), -1);
        // complete message: token, option, marker, payload
        dgram = '{8'h42, 8'h01, 8'h00, 8'h07, 8'hAA, 8'hBB, 8'hB1, 8'h61,
                  PAYLOAD_MARKER, 8'h68, 8'h69};
        send_datagram(dgram.size(), -1);
        wait_for_results();
    endtask

    task automatic test_option_limits();
        logic [5:0] limits[5];
        limits = '{6'd0, 6'd1, 6'd5, 6'd63, LIMIT_RESET};
        foreach (limits[i]) begin
            wait_for_results();
            set_option_limit(limits[i]);
            run_traffic(PHASE_BYTES);
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        repeat (4) begin
            wait_for_results();
            set_option_limit(6'($urandom_range(0, 63)));
            run_traffic(PHASE_BYTES);
        end
        wait_for_results();
    endtask

    // Test sequence
    initial begin
        option_limit_reg = LIMIT_RESET;
        clear_parse_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_directed_cases();
        test_option_limits();
        test_random_traffic();
        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
